// ===== design/arp_cache_responder_core_defines.svh =====
// ----------------------------------------------------------------------------
// arp cache responder assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_RESPONDER_CORE_DEFINES_SVH
`define ARP_CACHE_RESPONDER_CORE_DEFINES_SVH

// same-cycle implication
`define ARPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arpc same-cycle check failed");

// next-cycle implication
`define ARPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arpc next-cycle check failed");

`endif

// ===== design/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// widths, codes and sequencer types of the arp cache responder
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int OPC_W  = 16;
  localparam int ACT_W  = 3;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 4;

  localparam logic [OPC_W-1:0] OPC_REQUEST = 16'd1;
  localparam logic [OPC_W-1:0] OPC_REPLY   = 16'd2;

  localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REPLY = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LEARN = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FULL  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_HIT   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_MISS  = 3'd5;

  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  localparam logic [IP_W-1:0]  OWN_IP_RESET  = 32'h0A00_020F;
  localparam logic [MAC_W-1:0] OWN_MAC_RESET = 48'h5254_0012_3456;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef enum logic {
    KIND_QUERY,
    KIND_LEARN
  } kind_t;

endpackage

// ===== design/arpc_req_if.sv =====
// ----------------------------------------------------------------------------
// arpc_req_if
// request channel: received arp packet or resolve query
// ----------------------------------------------------------------------------
interface arpc_req_if
  import arpc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [OPC_W-1:0] arp_opcode;
  logic [IP_W-1:0]  sender_ip;
  logic [MAC_W-1:0] sender_mac;
  logic [IP_W-1:0]  target_ip;
  logic [IP_W-1:0]  query_ip;

  modport source (
    output valid, operation, arp_opcode, sender_ip, sender_mac, target_ip, query_ip,
    input  ready
  );
  modport sink (
    input  valid, operation, arp_opcode, sender_ip, sender_mac, target_ip, query_ip,
    output ready
  );
endinterface

// ===== design/arpc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// arpc_rsp_if
// result channel: action with peer address pair
// ----------------------------------------------------------------------------
interface arpc_rsp_if
  import arpc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [IP_W-1:0]  peer_ip;
  logic [MAC_W-1:0] peer_mac;

  modport source (
    output valid, action, peer_ip, peer_mac,
    input  ready
  );
  modport sink (
    input  valid, action, peer_ip, peer_mac,
    output ready
  );
endinterface

// ===== design/arp_cache_responder_core.sv =====
// ----------------------------------------------------------------------------
// arp_cache_responder_core
// arp cache and responder: answers requests for own ip, learns replies,
// resolves queries against a small cache walked by one shared comparator
// ----------------------------------------------------------------------------
//  channel   dir  protocol        content
//  req       in   valid/ready     operation, opcode, sender ip/mac, target ip, query ip
//  rsp       out  valid/ready     action, peer ip, peer mac
//  apb       in   psel/penable    own_ip at 0x0, own_mac at 0x8, 64-bit data
//
//  a request is taken only in idle; a packet request or unknown opcode goes
//  straight to emit, a query or reply first walks the cache up to the entry
//  that settles it or the last one, one entry per cycle
//  rst (synchronous) clears the valid bits, the sequencer and the output flag
//  a stalled rsp holds the result; the next request is taken meanwhile and
//  waits in emit until the output register frees up
// ----------------------------------------------------------------------------
`include "arp_cache_responder_core_defines.svh"

module arp_cache_responder_core
  import arpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // channels
  arpc_req_if.sink          req,
  arpc_rsp_if.source        rsp
);

  // configuration registers
  logic [IP_W-1:0]  own_ip;
  logic [MAC_W-1:0] own_mac;

  // cache store, valid bits reset, contents only written
  logic                     entry_valid [CACHE_ENTRIES];
  logic [IP_W-1:0]          entry_ip    [CACHE_ENTRIES];
  logic [MAC_W-1:0]         entry_mac   [CACHE_ENTRIES];

  // sequencer
  state_t           state, state_next;
  kind_t            kind, kind_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IP_W-1:0]  key_ip, key_ip_next;
  logic [MAC_W-1:0] key_mac, key_mac_next;

  // pending result
  logic [ACT_W-1:0] res_action, res_action_next;
  logic [IP_W-1:0]  res_ip, res_ip_next;
  logic [MAC_W-1:0] res_mac, res_mac_next;

  // output register
  logic             out_valid, out_valid_next;
  logic [ACT_W-1:0] out_action;
  logic [IP_W-1:0]  out_ip;
  logic [MAC_W-1:0] out_mac;
  logic             out_load;

  // shared compare unit and entry read at the walk index
  logic             rd_valid;
  logic [IP_W-1:0]  rd_ip;
  logic [MAC_W-1:0] rd_mac;
  logic             key_match;
  logic             last_entry;
  logic             wr_en;

  logic cfg_wr;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= OWN_IP_RESET;
      own_mac <= OWN_MAC_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_OWN_IP:  own_ip  <= pwdata[IP_W-1:0];
        REG_OWN_MAC: own_mac <= pwdata[MAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_OWN_IP:  prdata = {{(DATA_W-IP_W){1'b0}}, own_ip};
      REG_OWN_MAC: prdata = {{(DATA_W-MAC_W){1'b0}}, own_mac};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- walk unit
  assign rd_valid   = entry_valid[idx];
  assign rd_ip      = entry_ip[idx];
  assign rd_mac     = entry_mac[idx];
  assign key_match  = (rd_ip == key_ip);
  assign last_entry = (idx == IDX_W'(CACHE_ENTRIES - 1));

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind       <= kind_next;
    idx        <= idx_next;
    key_ip     <= key_ip_next;
    key_mac    <= key_mac_next;
    res_action <= res_action_next;
    res_ip     <= res_ip_next;
    res_mac    <= res_mac_next;
    if (out_load) begin
      out_action <= res_action;
      out_ip     <= res_ip;
      out_mac    <= res_mac;
    end
  end

  always_comb begin
    state_next      = state;
    kind_next       = kind;
    idx_next        = idx;
    key_ip_next     = key_ip;
    key_mac_next    = key_mac;
    res_action_next = res_action;
    res_ip_next     = res_ip;
    res_mac_next    = res_mac;
    wr_en           = 1'b0;
    out_load        = 1'b0;
    req.ready       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          idx_next     = '0;
          key_mac_next = req.sender_mac;
          if (req.operation) begin
            // resolve query walks the cache
            kind_next   = KIND_QUERY;
            key_ip_next = req.query_ip;
            state_next  = ST_SCAN;
          end else begin
            key_ip_next = req.sender_ip;
            case (req.arp_opcode)
              OPC_REQUEST: begin
                // answer only requests aimed at our address
                if (req.target_ip == own_ip) begin
                  res_action_next = ACT_REPLY;
                  res_ip_next     = req.sender_ip;
                  res_mac_next    = req.sender_mac;
                end else begin
                  res_action_next = ACT_NONE;
                  res_ip_next     = '0;
                  res_mac_next    = '0;
                end
                state_next = ST_EMIT;
              end
              OPC_REPLY: begin
                kind_next  = KIND_LEARN;
                state_next = ST_SCAN;
              end
              default: begin
                // unknown opcode, cache untouched
                res_action_next = ACT_NONE;
                res_ip_next     = '0;
                res_mac_next    = '0;
                state_next      = ST_EMIT;
              end
            endcase
          end
        end
      end

      ST_SCAN: begin
        res_ip_next = key_ip;
        if (kind == KIND_QUERY) begin
          if (rd_valid && key_match) begin
            res_action_next = ACT_HIT;
            res_mac_next    = rd_mac;
            state_next      = ST_EMIT;
          end else if (last_entry) begin
            res_action_next = ACT_MISS;
            res_mac_next    = '0;
            state_next      = ST_EMIT;
          end else begin
            idx_next = idx + 1'b1;
          end
        end else begin
          // first free slot or the slot already holding this ip
          res_mac_next = key_mac;
          if (!rd_valid || key_match) begin
            wr_en           = 1'b1;
            res_action_next = ACT_LEARN;
            state_next      = ST_EMIT;
          end else if (last_entry) begin
            res_action_next = ACT_FULL;
            state_next      = ST_EMIT;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end

      ST_EMIT: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end
  end

  // ---------------------------------------------------------------- cache store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        entry_valid[i] <= 1'b0;
      end
    end else if (wr_en) begin
      entry_valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_ip[idx]  <= key_ip;
      entry_mac[idx] <= key_mac;
    end
  end

  // ---------------------------------------------------------------- result port
  assign rsp.valid    = out_valid;
  assign rsp.action   = out_action;
  assign rsp.peer_ip  = out_ip;
  assign rsp.peer_mac = out_mac;

  // ---------------------------------------------------------------- checks
  // an accepted request always leaves idle
  `ARPC_ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, state != ST_IDLE)
  // a learn write marks its slot valid
  `ARPC_ASSERT_NEXT(a_learn_sets_valid, wr_en, entry_valid[$past(idx)])
  // a result waiting for the output register blocks new requests
  `ARPC_ASSERT_SAME(a_emit_blocks_req, state == ST_EMIT, !req.ready)
  // a loaded result is presented next cycle
  `ARPC_ASSERT_NEXT(a_load_shows_valid, out_load, rsp.valid)

endmodule

// ===== tb/arpc_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_tb_pkg
// testbench-side codes shared by the stimulus top and the outcome checker
// ----------------------------------------------------------------------------
package arpc_tb_pkg;

  import arpc_pkg::*;

  // request kinds carried on the operation bit
  localparam logic OPER_PACKET = 1'b0;
  localparam logic OPER_QUERY  = 1'b1;

  // 64-bit registers sit on an 8-byte stride
  localparam logic [ADDR_W-1:0] ADDR_OWN_IP  = ADDR_W'({REG_OWN_IP, 3'b000});
  localparam logic [ADDR_W-1:0] ADDR_OWN_MAC = ADDR_W'({REG_OWN_MAC, 3'b000});

endpackage

// ===== tb/arp_outcome_checker.sv =====
// ----------------------------------------------------------------------------
// arp_outcome_checker
// watches the request, result and register ports, keeps its own cache image
// and compares every result with the outcome predicted at request time
// ----------------------------------------------------------------------------
module arp_outcome_checker
  import arpc_pkg::*, arpc_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  arpc_req_if               req,
  arpc_rsp_if               rsp,
  output int                mismatches,
  output int                pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [IP_W-1:0]  peer_ip;
    logic [MAC_W-1:0] peer_mac;
  } arp_outcome_t;

  logic             cache_valid [CACHE_ENTRIES];
  logic [IP_W-1:0]  cache_ip    [CACHE_ENTRIES];
  logic [MAC_W-1:0] cache_mac   [CACHE_ENTRIES];
  logic [IP_W-1:0]  own_ip_now;
  arp_outcome_t     outcome_q [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // one outcome per request; learning updates the cache image
  function automatic arp_outcome_t predict_outcome(
    input logic             oper,
    input logic [OPC_W-1:0] opcode,
    input logic [IP_W-1:0]  s_ip,
    input logic [MAC_W-1:0] s_mac,
    input logic [IP_W-1:0]  t_ip,
    input logic [IP_W-1:0]  q_ip
  );
    arp_outcome_t o;
    o = '{ACT_NONE, '0, '0};
    if (oper == OPER_QUERY) begin
      o = '{ACT_MISS, q_ip, '0};
      for (int k = 0; k < CACHE_ENTRIES; k++) begin
        if (cache_valid[k] && cache_ip[k] == q_ip) begin
          o = '{ACT_HIT, q_ip, cache_mac[k]};
          return o;
        end
      end
      return o;
    end
    if (opcode == OPC_REQUEST) begin
      if (t_ip == own_ip_now) o = '{ACT_REPLY, s_ip, s_mac};
      return o;
    end
    if (opcode == OPC_REPLY) begin
      o = '{ACT_FULL, s_ip, s_mac};
      for (int k = 0; k < CACHE_ENTRIES; k++) begin
        if (!cache_valid[k] || cache_ip[k] == s_ip) begin
          cache_valid[k] = 1'b1;
          cache_ip[k]    = s_ip;
          cache_mac[k]   = s_mac;
          o.action       = ACT_LEARN;
          return o;
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    arp_outcome_t got;
    arp_outcome_t want;
    if (rst) begin
      for (int k = 0; k < CACHE_ENTRIES; k++) begin
        cache_valid[k] = 1'b0;
        cache_ip[k]    = '0;
        cache_mac[k]   = '0;
      end
      own_ip_now = OWN_IP_RESET;
      outcome_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_OWN_IP)
        own_ip_now = pwdata[IP_W-1:0];
      // results first: a request taken this edge cannot be answered this edge
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.action, rsp.peer_ip, rsp.peer_mac};
        if (outcome_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result exp none, got act %0d ip %h mac %h",
                   $time, got.action, got.peer_ip, got.peer_mac);
        end else begin
          want = outcome_q.pop_front();
          if (got.action != want.action || got.peer_ip != want.peer_ip ||
              got.peer_mac != want.peer_mac) begin
            mismatches++;
            $display("%0t: result mismatch exp act %0d ip %h mac %h, got act %0d ip %h mac %h",
                     $time, want.action, want.peer_ip, want.peer_mac,
                     got.action, got.peer_ip, got.peer_mac);
          end
        end
      end
      if (req.valid && req.ready)
        outcome_q.push_back(predict_outcome(req.operation, req.arp_opcode, req.sender_ip,
                                            req.sender_mac, req.target_ip, req.query_ip));
    end
    pending = outcome_q.size();
  end

endmodule

// ===== tb/tb_arp_cache_responder_core.sv =====
// ----------------------------------------------------------------------------
// tb_arp_cache_responder_core
// drives arp packets and resolve queries into the cache responder under
// random sender gaps and result stalls, rewrites own ip/mac between phases,
// and reports the verdict from the outcome checker
// ----------------------------------------------------------------------------
module tb_arp_cache_responder_core
  import arpc_pkg::*, arpc_tb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SIZE    = 20;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 300;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches;
  int pending;
  int cycle_count = 0;

  // idling knobs, percent chance to start a burst, per request for the sender and per cycle for the result side
  int send_gap_pct  = 0;
  int rsp_stall_pct = 0;

  // addresses that the cache may hold: 0, all ones, and tagged randoms
  logic [IP_W-1:0] known_ip [POOL_SIZE];
  logic [IP_W-1:0] cur_own_ip;

  arpc_req_if req_ch ();
  arpc_rsp_if rsp_ch ();

  arp_cache_responder_core DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  arp_outcome_checker outcome_chk (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("arp_cache_responder_core regression: fail");
      $finish;
    end
  end

  // result side: ready drops in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
        stall_left = $urandom_range(14);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return MAC_W'({$urandom(), $urandom()});
  endfunction

  // mostly addresses the cache knows about, so hits and relearns happen
  function automatic logic [IP_W-1:0] pick_ip(input int pool_pct);
    if ($urandom_range(99) < pool_pct) return known_ip[$urandom_range(POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // present one request and hold it until the block takes it
  task automatic offer_request(
    input logic             oper,
    input logic [OPC_W-1:0] opcode,
    input logic [IP_W-1:0]  s_ip,
    input logic [MAC_W-1:0] s_mac,
    input logic [IP_W-1:0]  t_ip,
    input logic [IP_W-1:0]  q_ip
  );
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= oper;
    req_ch.arp_opcode <= opcode;
    req_ch.sender_ip  <= s_ip;
    req_ch.sender_mac <= s_mac;
    req_ch.target_ip  <= t_ip;
    req_ch.query_ip   <= q_ip;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic release_request();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  // random sender gap after a request
  task automatic sender_gap();
    int gap;
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      gap = $urandom_range(1, 15);
      release_request();
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // hold off until every predicted result has come back
  task automatic drain();
    release_request();
    while (pending != 0) @(negedge clk);
  endtask

  // two-phase register write, only ever issued with the block idle
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_own(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
    write_reg(ADDR_OWN_IP, DATA_W'(ip));
    write_reg(ADDR_OWN_MAC, DATA_W'(mac));
    cur_own_ip = ip;
  endtask

  initial begin
    int pick;
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.operation  <= OPER_PACKET;
    req_ch.arp_opcode <= '0;
    req_ch.sender_ip  <= '0;
    req_ch.sender_mac <= '0;
    req_ch.target_ip  <= '0;
    req_ch.query_ip   <= '0;

    cur_own_ip  = OWN_IP_RESET;
    known_ip[0] = '0;
    known_ip[1] = '1;
    // top byte tags each address so the pool stays distinct
    for (int k = 2; k < POOL_SIZE; k++) known_ip[k] = {8'(k), 24'($urandom())};

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: empty cache, reset own_ip, light idling
    send_gap_pct  = 20;
    rsp_stall_pct = 20;

    // miss on an empty cache, packet fields ignored in a query
    offer_request(OPER_QUERY, OPC_REPLY, $urandom(), rand_mac(), $urandom(), '0);
    sender_gap();
    // request for us, sender ip and mac all ones
    offer_request(OPER_PACKET, OPC_REQUEST, '1, '1, OWN_IP_RESET, $urandom());
    sender_gap();
    // request for someone else
    offer_request(OPER_PACKET, OPC_REQUEST, $urandom(), rand_mac(), OWN_IP_RESET ^ 32'h1, '1);
    sender_gap();
    // unknown opcodes, even aimed at our address
    offer_request(OPER_PACKET, '0, '1, '1, OWN_IP_RESET, '1);
    sender_gap();
    offer_request(OPER_PACKET, '1, $urandom(), rand_mac(), OWN_IP_RESET, $urandom());
    sender_gap();
    // learn address zero with a zero mac, then hit it
    offer_request(OPER_PACKET, OPC_REPLY, '0, '0, $urandom(), $urandom());
    sender_gap();
    offer_request(OPER_QUERY, OPC_REQUEST, '1, '1, '1, '0);
    sender_gap();
    // learn all-ones, then relearn with a new mac and hit it
    offer_request(OPER_PACKET, OPC_REPLY, '1, '1, '0, '0);
    sender_gap();
    offer_request(OPER_PACKET, OPC_REPLY, '1, rand_mac(), $urandom(), $urandom());
    sender_gap();
    offer_request(OPER_QUERY, OPC_W'($urandom()), '0, '0, '0, '1);
    sender_gap();
    // fill the remaining entries
    for (int k = 2; k < CACHE_ENTRIES; k++) begin
      offer_request(OPER_PACKET, OPC_REPLY, known_ip[k], rand_mac(), $urandom(), $urandom());
      sender_gap();
    end
    // table full: new address dropped, known address still relearned
    offer_request(OPER_PACKET, OPC_REPLY, known_ip[CACHE_ENTRIES], rand_mac(), '0, '0);
    sender_gap();
    offer_request(OPER_PACKET, OPC_REPLY, known_ip[0], rand_mac(), '1, '1);
    sender_gap();
    // hit on the last entry of the walk
    offer_request(OPER_QUERY, OPC_REPLY, $urandom(), rand_mac(), $urandom(),
                  known_ip[CACHE_ENTRIES - 1]);

    // own address at both extremes
    drain();
    set_own('0, '0);
    offer_request(OPER_PACKET, OPC_REQUEST, $urandom(), rand_mac(), '0, $urandom());
    offer_request(OPER_PACKET, OPC_REQUEST, $urandom(), rand_mac(), '1, $urandom());
    drain();
    set_own('1, '1);
    offer_request(OPER_PACKET, OPC_REQUEST, $urandom(), rand_mac(), '1, $urandom());

    // random phases, each with its own idling mix and own address
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      set_own($urandom(), rand_mac());
      case (p)
        0: begin send_gap_pct = 0;  rsp_stall_pct = 30; end
        1: begin send_gap_pct = 30; rsp_stall_pct = 0;  end
        2: begin send_gap_pct = 20; rsp_stall_pct = 20; end
        3: begin send_gap_pct = 50; rsp_stall_pct = 50; end
        4: begin send_gap_pct = 10; rsp_stall_pct = 40; end
        default: begin send_gap_pct = 0; rsp_stall_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender waits out everything in flight once mid-run
        if (p == 2 && n == PHASE_ITEMS / 2) drain();
        pick = $urandom_range(99);
        if (pick < 35)
          offer_request(OPER_QUERY, OPC_W'($urandom()), $urandom(), rand_mac(), $urandom(),
                        pick_ip(70));
        else if (pick < 65)
          offer_request(OPER_PACKET, OPC_REPLY, pick_ip(80), rand_mac(), $urandom(),
                        $urandom());
        else if (pick < 90)
          offer_request(OPER_PACKET, OPC_REQUEST, $urandom(), rand_mac(),
                        ($urandom_range(1) != 0) ? cur_own_ip : pick_ip(50), $urandom());
        else
          offer_request(OPER_PACKET, OPC_W'($urandom()), $urandom(), rand_mac(), $urandom(),
                        $urandom());
        sender_gap();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("arp_cache_responder_core regression: pass");
    end else begin
      $display("arp_cache_responder_core regression: fail");
    end
    $finish;
  end

endmodule
